// ===== rtl/itt3_pkg.sv =====
// Shared constants, codes and types of the three-channel interval timer.
package itt3_pkg;

   localparam int COUNT_WIDTH      = 16;
   localparam int NUM_CHANNELS_DEF = 3;
   localparam int MAX_CHANNELS     = 3;

   typedef logic [COUNT_WIDTH-1:0] count_type;
   typedef logic [7:0]             byte_type;

   // Operation codes carried in the request word.
   localparam logic [2:0] OP_WRITE   = 3'd0;
   localparam logic [2:0] OP_READ    = 3'd1;
   localparam logic [2:0] OP_CLK_HI  = 3'd2;
   localparam logic [2:0] OP_CLK_LO  = 3'd3;
   localparam logic [2:0] OP_GATE_HI = 3'd4;
   localparam logic [2:0] OP_GATE_LO = 3'd5;

   localparam logic [1:0] PORT_CTRL = 2'd3;

   // Access modes from control word bits 5..4.
   localparam logic [1:0] ACC_LATCH = 2'd0;
   localparam logic [1:0] ACC_LO    = 2'd1;
   localparam logic [1:0] ACC_HI    = 2'd2;
   localparam logic [1:0] ACC_LOHI  = 2'd3;

   // Counting modes from control word bits 3..1.
   localparam logic [2:0] MODE_INT      = 3'd0;
   localparam logic [2:0] MODE_ONESHOT  = 3'd1;
   localparam logic [2:0] MODE_RATE     = 3'd2;
   localparam logic [2:0] MODE_SQUARE   = 3'd3;
   localparam logic [2:0] MODE_SWSTROBE = 3'd4;
   localparam logic [2:0] MODE_HWSTROBE = 3'd5;

   localparam byte_type READ_NONE = 8'hFF;

   // One-step command to a single channel; at most one flag is set.
   typedef struct packed {
      logic     wr_ctrl;
      logic     wr_data;
      logic     rd;
      logic     clk_hi;
      logic     clk_lo;
      logic     gate_hi;
      logic     gate_lo;
      byte_type data;
   } cmd_type;

   // What a channel reports for the step that it is given.
   typedef struct packed {
      logic     out_next;
      logic     rose;
      logic     fell;
      byte_type rd_byte;
   } chan_status_type;

endpackage

// ===== rtl/itt3_channel.sv =====
// One timer channel: count, reload, latch and out state with its step logic.
module itt3_channel (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        step,
   input  itt3_pkg::cmd_type           cmd,
   output itt3_pkg::chan_status_type   status
);

   itt3_pkg::count_type count_ff, count_in;
   itt3_pkg::count_type period_ff, period_in;
   itt3_pkg::count_type latch_ff, latch_in;
   logic                latch_vld_ff, latch_vld_in;
   logic                toggle_ff, toggle_in;
   logic [2:0]          mode_ff, mode_in;
   logic [1:0]          access_ff, access_in;
   logic                run_ff, run_in;
   logic                gate_ff, gate_in;
   logic                clk_ff, clk_in;
   logic                out_ff, out_in;
   itt3_pkg::byte_type  rd_byte;

   always_comb begin
      logic [2:0]          new_mode;
      itt3_pkg::count_type rd_val;
      itt3_pkg::count_type dec;
      itt3_pkg::count_type sub;
      itt3_pkg::count_type new_period;
      count_in     = count_ff;
      period_in    = period_ff;
      latch_in     = latch_ff;
      latch_vld_in = latch_vld_ff;
      toggle_in    = toggle_ff;
      mode_in      = mode_ff;
      access_in    = access_ff;
      run_in       = run_ff;
      gate_in      = gate_ff;
      clk_in       = clk_ff;
      out_in       = out_ff;
      rd_byte      = '0;
      new_mode     = {1'b0, cmd.data[2:1]};
      rd_val       = latch_vld_ff ? latch_ff : count_ff;
      dec          = count_ff - itt3_pkg::COUNT_WIDTH'(1);
      sub          = '0;
      new_period   = period_ff;

      if (cmd.wr_ctrl) begin
         toggle_in = 1'b0;
         if (cmd.data[5:4] == itt3_pkg::ACC_LATCH) begin
            latch_vld_in = 1'b1;
            latch_in     = count_ff;
         end else begin
            // Modes six and seven fold onto two and three.
            new_mode  = (cmd.data[3] && cmd.data[2]) ? {1'b0, cmd.data[2:1]} : cmd.data[3:1];
            mode_in   = new_mode;
            access_in = cmd.data[5:4];
            out_in    = (new_mode != itt3_pkg::MODE_INT);
         end
      end else if (cmd.wr_data) begin
         if (mode_ff == itt3_pkg::MODE_INT || mode_ff == itt3_pkg::MODE_SWSTROBE) begin
            // Direct count load.
            case (access_ff)
               itt3_pkg::ACC_LO: begin
                  count_in = {count_ff[15:8], cmd.data};
                  run_in   = 1'b1;
               end
               itt3_pkg::ACC_HI: begin
                  count_in = {cmd.data, count_ff[7:0]};
                  run_in   = 1'b1;
               end
               itt3_pkg::ACC_LOHI: begin
                  if (toggle_ff) begin
                     count_in  = {cmd.data, count_ff[7:0]};
                     run_in    = 1'b1;
                     toggle_in = 1'b0;
                  end else begin
                     count_in  = {count_ff[15:8], cmd.data};
                     run_in    = 1'b0;
                     toggle_in = 1'b1;
                  end
               end
               default: ;
            endcase
            if (mode_ff == itt3_pkg::MODE_INT) begin
               out_in = 1'b0;
            end
         end else begin
            // Period load; the count picks it up only when idle.
            if (access_ff == itt3_pkg::ACC_LO || access_ff == itt3_pkg::ACC_HI ||
                (access_ff == itt3_pkg::ACC_LOHI && toggle_ff)) begin
               new_period = (access_ff == itt3_pkg::ACC_LO) ? {period_ff[15:8], cmd.data}
                                                           : {cmd.data, period_ff[7:0]};
               period_in  = new_period;
               toggle_in  = 1'b0;
               if (!run_ff) begin
                  count_in = new_period;
               end
               run_in = 1'b1;
            end else if (access_ff == itt3_pkg::ACC_LOHI) begin
               period_in = {period_ff[15:8], cmd.data};
               toggle_in = 1'b1;
            end
            if (mode_ff == itt3_pkg::MODE_ONESHOT) begin
               run_in = 1'b0;
            end
         end
      end else if (cmd.rd) begin
         case (access_ff)
            itt3_pkg::ACC_LO: begin
               rd_byte      = rd_val[7:0];
               latch_vld_in = 1'b0;
            end
            itt3_pkg::ACC_HI: begin
               rd_byte      = rd_val[15:8];
               latch_vld_in = 1'b0;
            end
            itt3_pkg::ACC_LOHI: begin
               if (toggle_ff) begin
                  toggle_in    = 1'b0;
                  rd_byte      = rd_val[15:8];
                  latch_vld_in = 1'b0;
               end else begin
                  toggle_in = 1'b1;
                  rd_byte   = rd_val[7:0];
               end
            end
            default: ;
         endcase
      end else if (cmd.clk_hi) begin
         clk_in = 1'b1;
      end else if (cmd.clk_lo) begin
         if (clk_ff) begin
            clk_in = 1'b0;
            if (run_ff) begin
               case (mode_ff)
                  itt3_pkg::MODE_INT, itt3_pkg::MODE_ONESHOT,
                  itt3_pkg::MODE_SWSTROBE, itt3_pkg::MODE_HWSTROBE: begin
                     if (mode_ff == itt3_pkg::MODE_ONESHOT || gate_ff) begin
                        count_in = dec;
                        if (dec == '0) begin
                           run_in = 1'b0;
                           out_in = 1'b1;
                        end
                     end
                  end
                  itt3_pkg::MODE_RATE: begin
                     if (gate_ff && dec == '0) begin
                        out_in   = 1'b0;
                        count_in = period_ff;
                     end else begin
                        out_in = 1'b1;
                        if (gate_ff) begin
                           count_in = dec;
                        end
                     end
                  end
                  itt3_pkg::MODE_SQUARE: begin
                     if (gate_ff) begin
                        // Odd counts lose one while out is high, three while low.
                        if (count_ff[0]) begin
                           sub = count_ff - (out_ff ? itt3_pkg::COUNT_WIDTH'(1)
                                                    : itt3_pkg::COUNT_WIDTH'(3));
                        end else begin
                           sub = count_ff - itt3_pkg::COUNT_WIDTH'(2);
                        end
                        if (sub == '0) begin
                           out_in   = !out_ff;
                           count_in = period_ff;
                        end else begin
                           count_in = sub;
                        end
                     end
                  end
                  default: ;
               endcase
            end
         end
      end else if (cmd.gate_hi) begin
         gate_in = 1'b1;
         if (mode_ff inside {itt3_pkg::MODE_ONESHOT, itt3_pkg::MODE_RATE,
                             itt3_pkg::MODE_SQUARE, itt3_pkg::MODE_HWSTROBE}) begin
            run_in   = 1'b1;
            count_in = period_ff;
         end
      end else if (cmd.gate_lo) begin
         gate_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         period_ff    <= '0;
         latch_ff     <= '0;
         latch_vld_ff <= 1'b0;
         toggle_ff    <= 1'b0;
         mode_ff      <= itt3_pkg::MODE_INT;
         access_ff    <= itt3_pkg::ACC_LATCH;
         run_ff       <= 1'b0;
         gate_ff      <= 1'b1;
         clk_ff       <= 1'b0;
         out_ff       <= 1'b0;
      end else if (step) begin
         count_ff     <= count_in;
         period_ff    <= period_in;
         latch_ff     <= latch_in;
         latch_vld_ff <= latch_vld_in;
         toggle_ff    <= toggle_in;
         mode_ff      <= mode_in;
         access_ff    <= access_in;
         run_ff       <= run_in;
         gate_ff      <= gate_in;
         clk_ff       <= clk_in;
         out_ff       <= out_in;
      end
   end

   assign status.out_next = out_in;
   assign status.rose     = out_in && !out_ff;
   assign status.fell     = !out_in && out_ff;
   assign status.rd_byte  = rd_byte;

endmodule

// ===== rtl/interval_timer_three_channel.sv =====
// Top level of the three-channel interval timer with its stream ports.
//
// The block models a three-channel interval timer in the style of the 8253.
// Every request word is one event: a bus write, a bus read, a rising or
// falling edge of one channel's clock, or a rise or fall of one channel's
// gate. Counting happens on falling clock edges.
// Every request word yields exactly one response word that carries the read
// byte, the out level of every channel and any out edge the event caused.
// A request is first captured in an input register; once the output register
// is free or being drained, the channels update their state and the response
// is written to the output register. Throughput is one word per cycle while
// the receiver does not stall; each event's channel update completes before
// the next event may look at the state.
// When the receiver stalls, the response holds in the output register and
// one more request is held in the input register; req_tready then drops.
// Reset clears both valid flags and puts every channel in its power-up
// state: counts, periods and latches zero, access mode zero, gate high,
// clock low and out low. Channels at or above NUM_CHANNELS do not exist:
// their events are ignored and reads of them return 0xFF.
module interval_timer_three_channel #(
   parameter int NUM_CHANNELS = itt3_pkg::NUM_CHANNELS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // Fields from bit 0: operation[2:0], port[4:3], data[12:5], channel[14:13].
   input  logic [15:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // Fields from bit 0: read_data[7:0], out_levels[10:8], out_rose[11],
   // out_fell[12], changed_channel[14:13].
   output logic [15:0] rsp_tdata
);

   logic        in_vld_ff, in_vld_in;
   logic [14:0] in_word_ff, in_word_in;
   logic        rsp_vld_ff, rsp_vld_in;
   logic [14:0] rsp_word_ff, rsp_word_in;
   logic        advance;

   logic [2:0]         op;
   logic [1:0]         port;
   itt3_pkg::byte_type data;
   logic [1:0]         chan;

   itt3_pkg::cmd_type         cmd         [NUM_CHANNELS];
   itt3_pkg::chan_status_type chan_status [NUM_CHANNELS];

   itt3_pkg::byte_type read_data;
   logic [2:0]         out_levels;
   logic               out_rose;
   logic               out_fell;
   logic [1:0]         changed_channel;

   // The stage advances whenever the input register holds an event and the output register is free or being drained.
   assign advance    = in_vld_ff && (!rsp_vld_ff || rsp_tready);
   assign req_tready = !in_vld_ff || advance;

   always_comb begin
      in_vld_in  = in_vld_ff;
      in_word_in = in_word_ff;
      if (req_tvalid && req_tready) begin
         in_vld_in  = 1'b1;
         in_word_in = req_tdata[14:0];
      end else if (advance) begin
         in_vld_in = 1'b0;
      end
   end

   assign op   = in_word_ff[2:0];
   assign port = in_word_ff[4:3];
   assign data = in_word_ff[12:5];
   assign chan = in_word_ff[14:13];

   // Decode the event into a command for each channel that exists.
   for (genvar i = 0; i < NUM_CHANNELS; i++) begin : g_chan
      always_comb begin
         cmd[i].wr_ctrl = advance && op == itt3_pkg::OP_WRITE && port == itt3_pkg::PORT_CTRL
                          && data[7:6] == 2'(i);
         cmd[i].wr_data = advance && op == itt3_pkg::OP_WRITE && port == 2'(i);
         cmd[i].rd      = advance && op == itt3_pkg::OP_READ && port == 2'(i);
         cmd[i].clk_hi  = advance && op == itt3_pkg::OP_CLK_HI && chan == 2'(i);
         cmd[i].clk_lo  = advance && op == itt3_pkg::OP_CLK_LO && chan == 2'(i);
         cmd[i].gate_hi = advance && op == itt3_pkg::OP_GATE_HI && chan == 2'(i);
         cmd[i].gate_lo = advance && op == itt3_pkg::OP_GATE_LO && chan == 2'(i);
         cmd[i].data    = data;
      end

      itt3_channel u_channel (
         .clock  (clock),
         .reset  (reset),
         .step   (advance),
         .cmd    (cmd[i]),
         .status (chan_status[i])
      );
   end

   // Combine the channel reports; at most one channel acts per event.
   always_comb begin
      read_data       = '0;
      out_levels      = '0;
      out_rose        = 1'b0;
      out_fell        = 1'b0;
      changed_channel = '0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
         read_data     = read_data | chan_status[i].rd_byte;
         out_levels[i] = chan_status[i].out_next;
         out_rose      = out_rose | chan_status[i].rose;
         out_fell      = out_fell | chan_status[i].fell;
         if (chan_status[i].rose || chan_status[i].fell) begin
            changed_channel = 2'(i);
         end
      end
      // The control port and absent channels read as all ones.
      if (op == itt3_pkg::OP_READ && (port == itt3_pkg::PORT_CTRL ||
                                      32'(port) >= NUM_CHANNELS)) begin
         read_data = itt3_pkg::READ_NONE;
      end
   end

   always_comb begin
      rsp_vld_in  = rsp_vld_ff;
      rsp_word_in = rsp_word_ff;
      if (advance) begin
         rsp_vld_in  = 1'b1;
         rsp_word_in = {changed_channel, out_fell, out_rose, out_levels, read_data};
      end else if (rsp_tready) begin
         rsp_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      in_word_ff  <= in_word_in;
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {1'b0, rsp_word_ff};

   // A single event can move a single out in one direction only.
   a_one_edge: assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff |-> !(rsp_word_ff[11] && rsp_word_ff[12]))
      else $error("out rose and fell in the same step");

   // Without an out change the reported channel stays zero.
   a_chan_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_vld_ff && !rsp_word_ff[11] && !rsp_word_ff[12]) |-> rsp_word_ff[14:13] == 2'd0)
      else $error("changed channel set without an out change");

   // A processed event always lands in the output register.
   a_advance_lands: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_vld_ff)
      else $error("processed event produced no response");

   // An empty output register never blocks the input side.
   a_no_false_stall: assert property (@(posedge clock) disable iff (reset)
      !rsp_vld_ff |-> req_tready)
      else $error("input stalled while the output register was empty");

endmodule
